@@ design/necir_pkg.sv @@
package necir_pkg;

  // Input item commands
  localparam logic [1:0] CMD_CAPTURE = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_POLL    = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // Poll status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_INV_FAIL   = 2'd2;
  localparam logic [1:0] ST_USER_MISM  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_UNIT_PERIOD   = 1'b0;
  localparam logic CFG_EXPECTED_USER = 1'b1;

  localparam int DATA_W  = 16;
  localparam int CNT_W   = 8;
  localparam int QUO_W   = 8;
  localparam int STEP_W  = $clog2(DATA_W);

  // Frame timing thresholds, in unit periods or idle ticks
  localparam logic [CNT_W-1:0] IDLE_LIMIT     = 8'd56;
  localparam logic [QUO_W-1:0] LEADER_UNITS   = 8'd13;
  localparam logic [CNT_W-1:0] LEADER_IDLE    = 8'd8;
  localparam logic [QUO_W-1:0] SHORT_UNITS    = 8'd8;
  localparam logic [CNT_W-1:0] SHORT_IDLE     = 8'd5;
  localparam logic [QUO_W-1:0] LONG_UNITS     = 8'd110;
  localparam logic [QUO_W-1:0] OVERFLOW_UNITS = 8'd20;
  localparam logic [CNT_W-1:0] OVERFLOW_IDLE  = 8'd53;
  localparam logic [CNT_W-1:0] FRAME_BITS     = 8'd32;
  localparam logic [CNT_W-1:0] USER_BITS      = 8'd16;
  localparam logic [7:0]       INV_MATCH      = 8'hFF;

  localparam logic [DATA_W-1:0] UNIT_PERIOD_RST   = 16'd1;
  localparam logic [DATA_W-1:0] EXPECTED_USER_RST = 16'd0;

  typedef struct packed {
    logic [1:0]        command;
    logic [DATA_W-1:0] capture_count;
  } in_item_t;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_byte;
    logic [1:0] status;
  } out_item_t;

  // Frame engine operation strobes
  typedef struct packed {
    logic cap;
    logic tick;
    logic poll;
  } frm_ctl_t;

endpackage

@@ design/necir_div.sv @@
module necir_div
  import necir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  // Restoring divider, one quotient bit per cycle. The dividend shifts out
  // of quo_r from the top as quotient bits shift in at the bottom.
  // A zero divisor yields an all-ones quotient.
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = !diff[DATA_W];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rem_nxt  = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt  = {quo_r[DATA_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DATA_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[QUO_W-1:0];

endmodule

@@ design/necir_frame.sv @@
module necir_frame
  import necir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  frm_ctl_t          ctl,
  input  logic [QUO_W-1:0]  quotient,
  input  logic [DATA_W-1:0] expected_user,
  output out_item_t         poll_res
);

  logic [DATA_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]  bits_r, bits_nxt;
  logic [CNT_W-1:0]  idle_r, idle_nxt;
  logic [DATA_W-1:0] user_r, user_nxt;
  logic [CNT_W-1:0]  idle_inc;
  logic [7:0]        lo;
  logic [7:0]        hi;

  assign idle_inc = idle_r + 1'b1;
  assign lo       = shift_r[7:0];
  assign hi       = shift_r[15:8];

  always_comb begin
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    idle_nxt  = idle_r;
    user_nxt  = user_r;
    poll_res  = '{key_valid: 1'b0, key_byte: 8'd0, status: ST_OK};

    // Capture: classify the interval, first match wins
    if (ctl.cap) begin
      if (quotient <= QUO_W'(1)) begin
        shift_nxt = {1'b0, shift_r[DATA_W-1:1]};
        bits_nxt  = bits_r + 1'b1;
        idle_nxt  = '0;
      end else if (quotient == QUO_W'(2)) begin
        shift_nxt = {1'b1, shift_r[DATA_W-1:1]};
        bits_nxt  = bits_r + 1'b1;
        idle_nxt  = '0;
      end else if (quotient == LEADER_UNITS && idle_r < LEADER_IDLE) begin
        bits_nxt = '0;
      end else if (quotient < SHORT_UNITS && idle_r < SHORT_IDLE) begin
        bits_nxt = '0;
      end else if (quotient > LONG_UNITS && idle_r > OVERFLOW_IDLE) begin
        bits_nxt = '0;
      end else if (quotient > OVERFLOW_UNITS && idle_r > OVERFLOW_IDLE) begin
        bits_nxt = '0;
      end else begin
        idle_nxt = '0;
      end
      // user code sits in the register once 16 bits are in
      if (bits_nxt == USER_BITS) begin
        user_nxt = shift_nxt;
      end
    end

    // Tick: long silence restarts the frame
    if (ctl.tick) begin
      idle_nxt = idle_inc;
      if (idle_inc > IDLE_LIMIT) begin
        bits_nxt = '0;
      end
    end

    // Poll: check the frame, report the command byte
    if (ctl.poll) begin
      if (bits_r != FRAME_BITS) begin
        poll_res.status = ST_INCOMPLETE;
      end else if ((lo ^ hi) != INV_MATCH) begin
        bits_nxt        = '0;
        poll_res.status = ST_INV_FAIL;
      end else if (user_r != expected_user) begin
        poll_res.status = ST_USER_MISM;
      end else begin
        poll_res.key_valid = 1'b1;
        poll_res.key_byte  = lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      bits_r  <= '0;
      idle_r  <= '0;
      user_r  <= '0;
    end else begin
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      idle_r  <= idle_nxt;
      user_r  <= user_nxt;
    end
  end

endmodule

@@ design/nec_ir_pulse_decoder.sv @@
// NEC-style infrared frame decoder fed with timer-captured edge intervals.
// Input channel (in_valid/in_stall/in_item): each item is a capture, a tick,
// a poll or a no-op. A capture divides its count by unit_period with a
// bit-serial divider, one quotient bit per cycle, and then updates the frame
// state; the divider takes 16 steps, and the input is stalled meanwhile.
// Ticks, polls and no-ops are handled without the divider.
// Output channel (out_valid/out_stall/out_item): one item per poll, held in
// an output register and shown the cycle after the poll is accepted.
// Captures and ticks give no output item.
// While an output item waits under out_stall, captures and ticks are still
// taken; a further poll is held off until the waiting item is taken.
// Configuration (cfg_we/cfg_index/cfg_wdata): index 0 unit_period,
// index 1 expected_user; write only while the block is idle.
// Reset (rst_n low, synchronous) clears the frame state, drops any pending
// output item and sets unit_period to 1 and expected_user to 0.
module nec_ir_pulse_decoder
  import necir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [DATA_W-1:0] unit_period_r;
  logic [DATA_W-1:0] expected_user_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              in_fire;
  logic              out_fire;
  logic              div_done;
  logic [QUO_W-1:0]  quotient;
  frm_ctl_t          ctl;
  out_item_t         poll_res;

  // Accept unless dividing, or a poll would overwrite a waiting item
  assign in_stall = (state_r != S_IDLE) ||
                    (out_valid_r && out_stall && in_item.command == CMD_POLL);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_period_r   <= UNIT_PERIOD_RST;
      expected_user_r <= EXPECTED_USER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNIT_PERIOD:   unit_period_r   <= cfg_wdata;
        CFG_EXPECTED_USER: expected_user_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: captures wait for the divider
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire && in_item.command == CMD_CAPTURE) state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign ctl = '{cap:  div_done,
                 tick: in_fire && in_item.command == CMD_TICK,
                 poll: in_fire && in_item.command == CMD_POLL};

  necir_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire && in_item.command == CMD_CAPTURE),
    .dividend (in_item.capture_count),
    .divisor  (unit_period_r),
    .done     (div_done),
    .quotient (quotient)
  );

  necir_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .quotient      (quotient),
    .expected_user (expected_user_r),
    .poll_res      (poll_res)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.poll) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = poll_res;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_poll_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.poll |=> out_valid_r)
    else $error("accepted poll did not produce an output item");

  a_capture_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_item.command == CMD_CAPTURE) |=> state_r == S_DIV)
    else $error("capture did not enter divide state");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_key_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.key_valid) |-> out_item_r.status == ST_OK)
    else $error("key reported with non-ok status");

  a_no_key_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.key_valid) |-> out_item_r.key_byte == 8'd0)
    else $error("key byte nonzero without a key");

endmodule
